>>> design/tcbt_pkg.sv
package tcbt_pkg;

  localparam int VTX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int COST_IN_W = 16;
  localparam int SUM_W     = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic [1:0] CMD_EDGE   = 2'd0;
  localparam logic [1:0] CMD_VERTEX = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic KIND_TOUR = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic                 en;
    logic [VTX_W-1:0]     a;
    logic [VTX_W-1:0]     b;
    logic [COST_IN_W-1:0] cost;
  } cost_wr_t;

  typedef struct packed {
    logic             en;
    logic [VTX_W-1:0] prev;
    logic [VTX_W-1:0] cur;
    logic [VTX_W-1:0] first;
  } cost_rd_t;

  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] pos;
    logic [VTX_W-1:0] vtx;
    logic             improve;
  } tour_wr_t;

  typedef struct packed {
    logic             en;
    logic [VTX_W-1:0] idx;
  } tour_rd_t;

endpackage

>>> design/tcbt_cost_mem.sv
module tcbt_cost_mem
  import tcbt_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COST_BITS    = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cost_wr_t             wr,
  input  cost_rd_t             rd,
  output logic                 ready,
  output logic [COST_BITS-1:0] edge_cost,
  output logic [COST_BITS-1:0] close_cost
);

  localparam int TW    = $clog2(MAX_VERTICES);
  localparam int AW    = 2 * TW;
  localparam int DEPTH = 1 << AW;

  // upper triangle only: (a,b) and (b,a) share one entry
  logic [COST_BITS-1:0] mem [DEPTH];

  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] wr_addr, rd_addr_e, rd_addr_c;
  logic          wr_ok;
  logic [COST_BITS-1:0] edge_q, close_q;
  logic          edge_ok_r, close_ok_r;

  function automatic logic [AW-1:0] pair_addr(logic [VTX_W-1:0] x, logic [VTX_W-1:0] y);
    logic [TW-1:0] lo;
    logic [TW-1:0] hi;
    lo = (x < y) ? TW'(x) : TW'(y);
    hi = (x < y) ? TW'(y) : TW'(x);
    return {lo, hi};
  endfunction

  function automatic logic vtx_ok(logic [VTX_W-1:0] v);
    return int'(v) < MAX_VERTICES;
  endfunction

  assign wr_addr   = pair_addr(wr.a, wr.b);
  assign wr_ok     = wr.en && vtx_ok(wr.a) && vtx_ok(wr.b);
  assign rd_addr_e = pair_addr(rd.prev, rd.cur);
  assign rd_addr_c = pair_addr(rd.cur, rd.first);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_ok) begin
      mem[wr_addr] <= COST_BITS'(wr.cost);
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      edge_q     <= mem[rd_addr_e];
      close_q    <= mem[rd_addr_c];
      edge_ok_r  <= vtx_ok(rd.prev) && vtx_ok(rd.cur);
      close_ok_r <= vtx_ok(rd.cur) && vtx_ok(rd.first);
    end
  end

  assign ready      = !clr_busy_r;
  assign edge_cost  = edge_ok_r ? edge_q : '0;
  assign close_cost = close_ok_r ? close_q : '0;

endmodule

>>> design/tcbt_tour_mem.sv
module tcbt_tour_mem
  import tcbt_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tour_wr_t         wr,
  input  tour_rd_t         rd,
  output logic [VTX_W-1:0] best_vertex
);

  localparam int TW = $clog2(MAX_VERTICES);

  // two banks; per entry, cur_sel says where the current tour lives and
  // best_sel where the best one lives. Writes always go to the bank best
  // does not use, so a copy on improvement is just best_sel <= cur_sel.
  logic [VTX_W-1:0] bank0 [MAX_VERTICES];
  logic [VTX_W-1:0] bank1 [MAX_VERTICES];

  logic [MAX_VERTICES-1:0] cur_sel_r, cur_sel_nxt;
  logic [MAX_VERTICES-1:0] best_sel_r, best_sel_nxt;

  logic [TW-1:0]    waddr, raddr, ridx_r;
  logic             store, wbank;
  logic [VTX_W-1:0] q0, q1, fwd_r, d0, d1;
  logic             hit0_r, hit1_r, rok_r;

  assign waddr = TW'(wr.pos);
  assign store = wr.en && (int'(wr.pos) < MAX_VERTICES) && (int'(wr.vtx) < MAX_VERTICES);
  assign wbank = ~best_sel_r[waddr];
  assign raddr = TW'(rd.idx);

  always_comb begin
    cur_sel_nxt = cur_sel_r;
    if (store) cur_sel_nxt[waddr] = wbank;
    best_sel_nxt = (wr.en && wr.improve) ? cur_sel_nxt : best_sel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_sel_r  <= '0;
      best_sel_r <= '0;
    end else begin
      cur_sel_r  <= cur_sel_nxt;
      best_sel_r <= best_sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store && !wbank) bank0[waddr] <= wr.vtx;
    if (store && wbank) bank1[waddr] <= wr.vtx;
  end

  // read-before-write array; a write in the read cycle is forwarded
  always_ff @(posedge clk) begin
    if (rd.en) begin
      q0     <= bank0[raddr];
      q1     <= bank1[raddr];
      hit0_r <= store && !wbank && (waddr == raddr);
      hit1_r <= store && wbank && (waddr == raddr);
      fwd_r  <= wr.vtx;
      ridx_r <= raddr;
      rok_r  <= int'(rd.idx) < MAX_VERTICES;
    end
  end

  assign d0 = hit0_r ? fwd_r : q0;
  assign d1 = hit1_r ? fwd_r : q1;
  assign best_vertex = rok_r ? (best_sel_r[ridx_r] ? d1 : d0) : '0;

endmodule

>>> design/tour_cost_best_tracker_unit.sv
// Channel   Direction  Signals
// in_       slave      in_tvalid, in_tready, in_tuser (cmd), in_tdata (item fields)
// out_      master     out_tvalid, out_tready, out_tuser (result_kind), out_tdata
// cfg_      write      cfg_wr_en, cfg_wr_data (vertex_count)
//
// One transaction per cycle while in_tready is high; a result passes stage 1
// (matrix read, running sum), stage 2 (closing add, best compare), output reg.
// After reset the cost matrix is swept to zero, one entry a cycle, over all
// 4**clog2(MAX_VERTICES) entries (4096 by default), in_tready low meanwhile.
// A stalled output fills the two inner stages before in_tready drops.
module tour_cost_best_tracker_unit
  import tcbt_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COST_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,     // cmd
  input  logic [39:0] in_tdata,     // vertex_a, vertex_b, edge_cost, tour_vertex, read_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [0:0]  out_tuser,    // result_kind
  output logic [71:0] out_tdata,    // tour_cost, best_cost, improved, best_vertex, pad
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data   // vertex_count
);

  logic [1:0]           in_cmd;
  logic [VTX_W-1:0]     in_va, in_vb, in_tv, in_ri;
  logic [COST_IN_W-1:0] in_cost;

  assign in_cmd  = in_tuser;
  assign in_va   = in_tdata[5:0];
  assign in_vb   = in_tdata[11:6];
  assign in_cost = in_tdata[27:12];
  assign in_tv   = in_tdata[33:28];
  assign in_ri   = in_tdata[39:34];

  logic [CNT_W-1:0] vcount_r, count_eff;
  logic [CNT_W-1:0] pos_r, pos_inc;
  logic [VTX_W-1:0] first_r, prev_r;
  logic             closing, accept, is_vtx;
  logic             cost_ready;

  logic             s0_adv, s1_adv, s2_adv;
  logic             s1_valid_r, s1_read_r, s1_first_r, s1_close_r;
  logic [CNT_W-1:0] s1_pos_r;
  logic [VTX_W-1:0] s1_tv_r, s1_ri_r;

  logic             s2_valid_r, s2_read_r, s2_close_r;
  logic [SUM_W-1:0] s2_sum_r;
  logic [COST_BITS-1:0] s2_close_cost_r;
  logic [CNT_W-1:0] s2_pos_r;
  logic [VTX_W-1:0] s2_tv_r;

  logic [SUM_W-1:0] sum_r, s1_sum, lowest_r, total;
  logic [SUM_W:0]   sum_add, tot_add;
  logic             better;

  logic [COST_BITS-1:0] edge_cost, close_cost;
  logic [VTX_W-1:0]     tm_vertex;

  cost_wr_t cwr;
  cost_rd_t crd;
  tour_wr_t twr;
  tour_rd_t trd;

  logic             out_valid_r, out_kind_r, out_improved_r;
  logic [SUM_W-1:0] out_tour_cost_r, out_best_cost_r;
  logic [VTX_W-1:0] out_best_vertex_r;

  always_comb begin
    if (vcount_r < CNT_W'(2)) begin
      count_eff = CNT_W'(2);
    end else if (int'(vcount_r) > MAX_VERTICES) begin
      count_eff = CNT_W'(MAX_VERTICES);
    end else begin
      count_eff = vcount_r;
    end
  end

  assign s2_adv    = !out_valid_r || out_tready;
  assign s1_adv    = !s2_valid_r || s2_adv;
  assign s0_adv    = !s1_valid_r || s1_adv;
  assign in_tready = cost_ready && s0_adv;
  assign accept    = in_tvalid && in_tready;
  assign is_vtx    = in_cmd == CMD_VERTEX;
  assign pos_inc   = pos_r + CNT_W'(1);
  assign closing   = pos_inc >= count_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= CNT_W'(64);
    end else if (cfg_wr_en) begin
      vcount_r <= cfg_wr_data;
    end
  end

  // tour position tracking at the front, so both matrix reads go out at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      first_r <= '0;
      prev_r  <= '0;
    end else if (accept && is_vtx) begin
      pos_r  <= closing ? '0 : pos_inc;
      prev_r <= in_tv;
      if (pos_r == '0) first_r <= in_tv;
    end
  end

  assign cwr.en    = accept && (in_cmd == CMD_EDGE);
  assign cwr.a     = in_va;
  assign cwr.b     = in_vb;
  assign cwr.cost  = in_cost;
  assign crd.en    = accept && is_vtx;
  assign crd.prev  = prev_r;
  assign crd.cur   = in_tv;
  assign crd.first = first_r;

  tcbt_cost_mem #(
    .MAX_VERTICES (MAX_VERTICES),
    .COST_BITS    (COST_BITS)
  ) u_cost_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (cwr),
    .rd         (crd),
    .ready      (cost_ready),
    .edge_cost  (edge_cost),
    .close_cost (close_cost)
  );

  // stage 1: running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s0_adv) begin
      s1_valid_r <= accept && (is_vtx || (in_cmd == CMD_READ));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read_r  <= in_cmd == CMD_READ;
      s1_first_r <= pos_r == '0;
      s1_close_r <= closing;
      s1_pos_r   <= pos_r;
      s1_tv_r    <= in_tv;
      s1_ri_r    <= in_ri;
    end
  end

  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(edge_cost);
  assign s1_sum  = s1_first_r ? '0 : (sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (s1_valid_r && s1_adv && !s1_read_r) begin
      sum_r <= s1_sum;
    end
  end

  assign trd.en  = s1_valid_r && s1_adv && s1_read_r;
  assign trd.idx = s1_ri_r;

  // stage 2: closing edge, best compare, tour write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      s2_read_r       <= s1_read_r;
      s2_close_r      <= s1_close_r;
      s2_sum_r        <= s1_sum;
      s2_close_cost_r <= close_cost;
      s2_pos_r        <= s1_pos_r;
      s2_tv_r         <= s1_tv_r;
    end
  end

  assign tot_add = {1'b0, s2_sum_r} + (SUM_W + 1)'(s2_close_cost_r);
  assign total   = tot_add[SUM_W] ? SUM_MAX : tot_add[SUM_W-1:0];
  // a read carries a stale close flag, so only tour vertices may improve
  assign better  = s2_close_r && !s2_read_r && (total < lowest_r);

  assign twr.en      = s2_valid_r && s2_adv && !s2_read_r;
  assign twr.pos     = s2_pos_r;
  assign twr.vtx     = s2_tv_r;
  assign twr.improve = better;

  tcbt_tour_mem #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_tour_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr          (twr),
    .rd          (trd),
    .best_vertex (tm_vertex)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_r <= SUM_MAX;
    end else if (twr.en && better) begin
      lowest_r <= total;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= s2_valid_r && (s2_read_r || s2_close_r);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_valid_r) begin
      out_kind_r        <= s2_read_r ? KIND_READ : KIND_TOUR;
      out_tour_cost_r   <= s2_read_r ? '0 : total;
      out_best_cost_r   <= better ? total : lowest_r;
      out_improved_r    <= better;
      out_best_vertex_r <= s2_read_r ? tm_vertex : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {1'b0, out_best_vertex_r, out_improved_r, out_best_cost_r,
                       out_tour_cost_r};

endmodule
